// File: hw/rtl/pra_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pra_pkg
// Types and constants shared by the priority resource allocator.
// ----------------------------------------------------------------------------
package pra_pkg;

    localparam int QDEPTH  = 16;
    localparam int QIDX_W  = $clog2(QDEPTH);
    localparam int LEN_W   = $clog2(QDEPTH + 1);
    localparam int UNITS_W = 16;
    localparam int ID_W    = 8;
    localparam int PRIO_W  = 8;
    localparam int WCNT_W  = 5;

    localparam logic [UNITS_W-1:0] UNITS_MAX = '1;

    typedef enum logic [0:0] {
        FN_ALLOC   = 1'b0,
        FN_RELEASE = 1'b1
    } t_func;

    typedef enum logic [2:0] {
        ST_GRANT     = 3'd0,
        ST_QUEUED    = 3'd1,
        ST_FULL      = 3'd2,
        ST_REL_NONE  = 3'd3,
        ST_REL_GRANT = 3'd4
    } t_status;

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic load_in;
        logic exec;
    } t_pra_cmd;

    typedef struct packed {
        logic out_free;
    } t_pra_sts;

endpackage
`default_nettype wire

// File: hw/rtl/pra_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pra_ctrl
// Sequencer: takes an item, then runs one update step once the output
// register is free.
// ----------------------------------------------------------------------------
module pra_ctrl
    import pra_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_s_tvalid,
    output logic          o_s_tready,
    input  wire t_pra_sts i_sts,
    output t_pra_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready    = 1'b0;
        o_cmd.load_in = 1'b0;
        o_cmd.exec    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready    = 1'b1;
                o_cmd.load_in = i_s_tvalid;
            end
            S_EXEC: begin
                o_cmd.exec = i_sts.out_free;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// File: hw/rtl/pra_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pra_dpath
// Free-unit counter, sorted wait list with parallel compare-and-shift insert,
// and the result register.
// ----------------------------------------------------------------------------
module pra_dpath
    import pra_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_pra_cmd           i_cmd,
    output t_pra_sts                o_sts,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [UNITS_W-1:0] i_cfg_wr_data,
    input  wire logic               i_func,
    input  wire logic [ID_W-1:0]    i_requester_id,
    input  wire logic [UNITS_W-1:0] i_unit_count,
    input  wire logic [PRIO_W-1:0]  i_priority_req,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    output logic [2:0]              o_status,
    output logic [ID_W-1:0]         o_granted_requester,
    output logic [UNITS_W-1:0]      o_available_after,
    output logic [WCNT_W-1:0]       o_waiting_count
);

    // latched item
    logic               r_in_func;
    logic [ID_W-1:0]    r_in_id;
    logic [UNITS_W-1:0] r_in_units;
    logic [PRIO_W-1:0]  r_in_prio;

    // pool and wait list
    logic [UNITS_W-1:0] r_avail;
    logic [UNITS_W-1:0] n_avail;
    logic [LEN_W-1:0]   r_len;
    logic [LEN_W-1:0]   n_len;
    logic [PRIO_W-1:0]  r_prio  [QDEPTH];
    logic [ID_W-1:0]    r_req   [QDEPTH];
    logic [UNITS_W-1:0] r_units [QDEPTH];
    logic [PRIO_W-1:0]  n_prio  [QDEPTH];
    logic [ID_W-1:0]    n_req   [QDEPTH];
    logic [UNITS_W-1:0] n_units [QDEPTH];

    // result register
    logic               r_o_valid;
    t_status            r_o_status;
    t_status            n_o_status;
    logic [ID_W-1:0]    r_o_granted;
    logic [ID_W-1:0]    n_o_granted;
    logic [UNITS_W-1:0] r_o_avail;
    logic [LEN_W-1:0]   r_o_len;

    logic [QDEPTH-1:0]  w_gt;
    logic [QDEPTH-1:0]  w_shift;
    logic [UNITS_W:0]   w_sum;
    logic [UNITS_W-1:0] w_sat;
    logic               w_full;

    always_comb begin
        for (int i = 0; i < QDEPTH; i++) begin
            w_gt[i] = (LEN_W'(i) < r_len) && (r_prio[i] > r_in_prio);
        end
    end

    // entry i takes entry i-1 when that one moves up
    assign w_shift = {w_gt[QDEPTH-2:0], 1'b0};

    assign w_full = (r_len >= LEN_W'(QDEPTH));
    assign w_sum  = {1'b0, r_avail} + {1'b0, r_in_units};
    assign w_sat  = w_sum[UNITS_W] ? UNITS_MAX : w_sum[UNITS_W-1:0];

    always_comb begin
        n_avail     = r_avail;
        n_len       = r_len;
        n_o_status  = ST_REL_NONE;
        n_o_granted = '0;
        for (int i = 0; i < QDEPTH; i++) begin
            n_prio[i]  = r_prio[i];
            n_req[i]   = r_req[i];
            n_units[i] = r_units[i];
        end
        if (r_in_func == FN_ALLOC) begin
            if (r_avail >= r_in_units) begin
                n_avail    = r_avail - r_in_units;
                n_o_status = ST_GRANT;
            end else if (w_full) begin
                n_o_status = ST_FULL;
            end else begin
                n_o_status = ST_QUEUED;
                n_len      = r_len + LEN_W'(1);
                // entries above the insert point move up one place
                for (int i = 0; i < QDEPTH; i++) begin
                    if (w_shift[i]) begin
                        n_prio[i]  = r_prio[i-1];
                        n_req[i]   = r_req[i-1];
                        n_units[i] = r_units[i-1];
                    end else if (w_gt[i] || LEN_W'(i) == r_len) begin
                        n_prio[i]  = r_in_prio;
                        n_req[i]   = r_in_id;
                        n_units[i] = r_in_units;
                    end
                end
            end
        end else begin
            n_avail    = w_sat;
            n_o_status = ST_REL_NONE;
            if (r_len != '0 && r_units[0] <= w_sat) begin
                n_avail     = w_sat - r_units[0];
                n_o_granted = r_req[0];
                n_o_status  = ST_REL_GRANT;
                n_len       = r_len - LEN_W'(1);
                for (int i = 0; i < QDEPTH - 1; i++) begin
                    n_prio[i]  = r_prio[i+1];
                    n_req[i]   = r_req[i+1];
                    n_units[i] = r_units[i+1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in_func  <= i_func;
            r_in_id    <= i_requester_id;
            r_in_units <= i_unit_count;
            r_in_prio  <= i_priority_req;
        end
        if (i_cmd.exec) begin
            for (int i = 0; i < QDEPTH; i++) begin
                r_prio[i]  <= n_prio[i];
                r_req[i]   <= n_req[i];
                r_units[i] <= n_units[i];
            end
            r_o_status  <= n_o_status;
            r_o_granted <= n_o_granted;
            r_o_avail   <= n_avail;
            r_o_len     <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avail   <= '0;
            r_len     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_avail <= i_cfg_wr_data;
            end else if (i_cmd.exec) begin
                r_avail <= n_avail;
            end
            if (i_cmd.exec) begin
                r_len <= n_len;
            end
            if (i_cmd.exec) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_free      = !r_o_valid || i_out_ready;
    assign o_out_valid         = r_o_valid;
    assign o_status            = r_o_status;
    assign o_granted_requester = r_o_granted;
    assign o_available_after   = r_o_avail;
    assign o_waiting_count     = WCNT_W'(r_o_len);

endmodule
`default_nettype wire

// File: hw/rtl/priority_resource_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// priority_resource_allocator
// Counting resource pool with a priority-ordered wait list.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake          Payload
// s        in   tvalid/tready      tuser: func; tdata: id, units, priority
// m        out  tvalid/tready      tuser: status; tdata: granted id, free, waiters
// cfg      in   wr_en              wr_data: initial_amount (also loads pool)
//
// The sequencer registers an item, then updates the pool and the wait list and
// loads the result register, taking no new item in between. The next item is
// taken while the result waits. The update step holds while the result register
// is still full and not being taken. Reset is synchronous: empty list, no free units.
// ----------------------------------------------------------------------------
module priority_resource_allocator
    import pra_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [15:0] i_cfg_wr_data,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // requester_id[7:0], unit_count, priority_req
    input  wire logic [0:0]  i_s_tuser,   // func
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,   // granted_requester, available_after,
                                          // waiting_count, zero pad
    output logic [2:0]       o_m_tuser    // status
);

    t_pra_cmd            w_cmd;
    t_pra_sts            w_sts;
    logic [2:0]          w_status;
    logic [ID_W-1:0]     w_granted;
    logic [UNITS_W-1:0]  w_avail;
    logic [WCNT_W-1:0]   w_wcnt;

    pra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pra_dpath u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_sts               (w_sts),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_wr_data       (i_cfg_wr_data),
        .i_func              (i_s_tuser[0]),
        .i_requester_id      (i_s_tdata[7:0]),
        .i_unit_count        (i_s_tdata[23:8]),
        .i_priority_req      (i_s_tdata[31:24]),
        .i_out_ready         (i_m_tready),
        .o_out_valid         (o_m_tvalid),
        .o_status            (w_status),
        .o_granted_requester (w_granted),
        .o_available_after   (w_avail),
        .o_waiting_count     (w_wcnt)
    );

    assign o_m_tuser = w_status;
    assign o_m_tdata = {3'b000, w_wcnt, w_avail, w_granted};

    a_take_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("item taken while previous one in progress");

    a_exec_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.exec |=> o_m_tvalid)
        else $error("update step did not present a result");

    a_wcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (w_wcnt <= WCNT_W'(QDEPTH)))
        else $error("waiter count beyond list depth");

    a_grant_id_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && w_status != ST_REL_GRANT) |-> (w_granted == '0))
        else $error("granted id set without a release grant");

endmodule
`default_nettype wire

// File: test/pra_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pra_checker
// Watches the request, result and register channels of the priority resource
// allocator. It keeps its own copy of the pool and wait list, works out the
// outcome of every accepted item and compares each result with the oldest
// outcome still owed. It hands the mismatch count and the number of owed
// results to the testbench top.
// ----------------------------------------------------------------------------
module pra_checker
    import pra_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [15:0] i_cfg_wr_data,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [31:0] i_s_tdata,   // requester_id, unit_count, priority_req
    input  wire logic [0:0]  i_s_tuser,   // func
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [31:0] i_m_tdata,   // granted_requester, available_after,
                                          // waiting_count, zero pad
    input  wire logic [2:0]  i_m_tuser,   // status
    output int               o_errors,
    output int               o_pending,
    output int               o_checked
);

    typedef struct packed {
        t_status             status;
        logic [ID_W-1:0]     granted;
        logic [UNITS_W-1:0]  free;
        logic [WCNT_W-1:0]   waiters;
    } t_outcome;

    logic [UNITS_W-1:0] free_units = '0;
    logic [PRIO_W-1:0]  wl_prio  [QDEPTH];
    logic [ID_W-1:0]    wl_id    [QDEPTH];
    logic [UNITS_W-1:0] wl_units [QDEPTH];
    int                 wl_len = 0;

    t_outcome outcome_q [$];
    int       n_err = 0;
    int       n_pending = 0;
    int       n_checked = 0;

    assign o_errors  = n_err;
    assign o_pending = n_pending;
    assign o_checked = n_checked;

    task automatic flag_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        n_err++;
    endtask

    // Applies one request or release to the pool and wait list.
    task automatic pool_step(input t_func fn, input logic [ID_W-1:0] id,
                             input logic [UNITS_W-1:0] units,
                             input logic [PRIO_W-1:0] prio, output t_outcome res);
        int              pos;
        logic [UNITS_W:0] sum;
        res = '0;
        if (fn == FN_ALLOC) begin
            if (free_units >= units) begin
                free_units = free_units - units;
                res.status = ST_GRANT;
            end else if (wl_len >= QDEPTH) begin
                res.status = ST_FULL;
            end else begin
                // behind every waiter of lower or equal priority value
                pos = wl_len;
                while (pos > 0 && wl_prio[pos-1] > prio) begin
                    wl_prio[pos]  = wl_prio[pos-1];
                    wl_id[pos]    = wl_id[pos-1];
                    wl_units[pos] = wl_units[pos-1];
                    pos--;
                end
                wl_prio[pos]  = prio;
                wl_id[pos]    = id;
                wl_units[pos] = units;
                wl_len++;
                res.status = ST_QUEUED;
            end
        end else begin
            sum = {1'b0, free_units} + {1'b0, units};
            free_units = sum[UNITS_W] ? UNITS_MAX : sum[UNITS_W-1:0];
            res.status = ST_REL_NONE;
            if (wl_len > 0 && wl_units[0] <= free_units) begin
                free_units  = free_units - wl_units[0];
                res.granted = wl_id[0];
                for (int i = 1; i < wl_len; i++) begin
                    wl_prio[i-1]  = wl_prio[i];
                    wl_id[i-1]    = wl_id[i];
                    wl_units[i-1] = wl_units[i];
                end
                wl_len--;
                res.status = ST_REL_GRANT;
            end
        end
        res.free    = free_units;
        res.waiters = wl_len[WCNT_W-1:0];
    endtask

    always @(posedge i_clk) begin : watch
        t_outcome got;
        t_outcome want;
        if (!i_rst_n) begin
            free_units = '0;
            wl_len     = 0;
            outcome_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                free_units = i_cfg_wr_data;
            end
            if (i_m_tvalid && i_m_tready) begin
                got.status  = t_status'(i_m_tuser);
                got.granted = i_m_tdata[7:0];
                got.free    = i_m_tdata[23:8];
                got.waiters = i_m_tdata[28:24];
                if (outcome_q.size() == 0) begin
                    flag_mismatch($sformatf("result 0x%08h/%0d with nothing owed",
                                            i_m_tdata, i_m_tuser));
                end else begin
                    want = outcome_q[0];
                    outcome_q.delete(0);
                    if (got.status !== want.status)
                        flag_mismatch($sformatf("result %0d status %0d, want %0d",
                                                n_checked, got.status, want.status));
                    if (got.granted !== want.granted)
                        flag_mismatch($sformatf("result %0d granted id %0d, want %0d",
                                                n_checked, got.granted, want.granted));
                    if (got.free !== want.free)
                        flag_mismatch($sformatf("result %0d free units %0d, want %0d",
                                                n_checked, got.free, want.free));
                    if (got.waiters !== want.waiters)
                        flag_mismatch($sformatf("result %0d waiters %0d, want %0d",
                                                n_checked, got.waiters, want.waiters));
                    if (i_m_tdata[31:29] !== 3'b000)
                        flag_mismatch($sformatf("result %0d pad bits %b",
                                                n_checked, i_m_tdata[31:29]));
                    n_checked++;
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                pool_step(t_func'(i_s_tuser), i_s_tdata[7:0], i_s_tdata[23:8],
                          i_s_tdata[31:24], want);
                outcome_q.push_back(want);
            end
        end
        n_pending = outcome_q.size();
    end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the priority resource allocator. A directed run
// covers zero-unit grants, saturating releases, equal-priority ordering, a
// head that does not fit and a full wait list; random phases follow, each
// after a fresh pool load, with bursty requests and a stalling result side.
// ----------------------------------------------------------------------------
module tb_top;
    import pra_pkg::*;

    localparam int IDLE_LIMIT   = 5000;
    localparam int SETTLE_CYC   = 8;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 75;

    localparam int RDY_ALWAYS = 0;
    localparam int RDY_MOSTLY = 1;
    localparam int RDY_RARELY = 2;
    localparam int RDY_HOLD   = 3;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [15:0] i_cfg_wr_data = '0;
    logic        s_tvalid      = 1'b0;
    logic [31:0] s_tdata       = '0;
    logic [0:0]  s_tuser       = '0;
    logic        m_tready      = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;

    int errors;
    int pending;
    int checked;

    int n_items     = 0;
    int n_loads     = 0;
    int burst_left  = 0;
    int idle_cycles = 0;
    int rdy_mode    = RDY_ALWAYS;
    int rdy_left    = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    priority_resource_allocator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (s_tvalid),
        .o_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .o_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .o_m_tdata     (m_tdata),
        .o_m_tuser     (m_tuser)
    );

    pra_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    // result side: the stall pattern is redrawn at random once its run ends
    always @(posedge i_clk) begin
        if (rdy_left == 0) begin
            rdy_mode <= $urandom_range(RDY_ALWAYS, RDY_HOLD);
            rdy_left <= $urandom_range(8, 60);
        end else begin
            rdy_left <= rdy_left - 1;
        end
        case (rdy_mode)
            RDY_ALWAYS: m_tready <= 1'b1;
            RDY_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
            RDY_RARELY: m_tready <= ($urandom_range(0, 3) == 0);
            default:    m_tready <= 1'b0;
        endcase
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results owed",
                     idle_cycles, pending);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_item(input t_func fn, input logic [7:0] id,
                             input logic [15:0] units, input logic [7:0] prio);
        int gap;
        s_tdata  <= {prio, units, id};
        s_tuser  <= fn;
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
        n_items++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // drain every owed result, then let the pipeline go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic load_pool(input logic [15:0] value);
        i_cfg_wr_data <= value;
        i_cfg_wr_en   <= 1'b1;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        n_loads++;
    endtask

    initial begin : stimulus
        int          ph;
        int          k;
        int          sel;
        t_func       fn;
        logic [15:0] units;
        logic [15:0] load_val;
        logic [7:0]  prio;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: pool starts empty
        send_item(FN_ALLOC,   8'd0,   16'd0,     8'd0);    // zero units, empty pool
        send_item(FN_RELEASE, 8'd0,   16'd50,    8'd0);    // release, nobody waiting
        send_item(FN_ALLOC,   8'd255, 16'hFFFF,  8'd255);
        send_item(FN_ALLOC,   8'd0,   16'd60,    8'd0);
        send_item(FN_ALLOC,   8'd1,   16'd60,    8'd0);    // tie behind id 0
        send_item(FN_RELEASE, 8'd2,   16'd5,     8'd0);    // head does not fit
        send_item(FN_RELEASE, 8'd3,   16'd10,    8'd9);    // head granted
        send_item(FN_RELEASE, 8'd4,   16'hFFFF,  8'd255);  // saturates, grant
        send_item(FN_RELEASE, 8'd5,   16'd0,     8'd0);
        for (k = 0; k < 16; k++) begin
            // fills the list, the last one is turned away
            prio = (k % 3 == 0) ? 8'd128 : 8'(k * 73);
            send_item(FN_ALLOC, 8'(k + 16), 16'hFFFF - 16'(k), prio);
        end

        for (ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph)
                0:       load_val = 16'hFFFF;
                1:       load_val = 16'd0;
                2:       load_val = 16'($urandom);
                3:       load_val = 16'd1;
                4:       load_val = 16'($urandom_range(0, 400));
                default: load_val = 16'($urandom_range(0, 65535));
            endcase
            load_pool(load_val);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                fn  = ($urandom_range(0, 99) < 55) ? FN_ALLOC : FN_RELEASE;
                sel = $urandom_range(0, 9);
                case (sel)
                    0:       units = 16'd0;
                    1:       units = 16'hFFFF;
                    2:       units = 16'($urandom);
                    default: units = 16'($urandom_range(1, 120));
                endcase
                prio = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
                send_item(fn, 8'($urandom), units, prio);
            end
        end

        settle();
        $display("covered %0d items across %0d pool loads; %0d results checked",
                 n_items, n_loads, checked);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", errors);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/pra_pkg.sv
hw/rtl/pra_ctrl.sv
hw/rtl/pra_dpath.sv
hw/rtl/priority_resource_allocator.sv
test/pra_checker.sv
test/tb_top.sv
